FILE: hdl/trhd_pkg.sv
`timescale 1ns / 1ps

package trhd_pkg;

   localparam int unsigned SCR_X_SPAN = 800;
   localparam int unsigned SCR_Y_SPAN = 480;
   localparam int unsigned RAW_X_SPAN = 51200;
   localparam int unsigned RAW_Y_SPAN = 7680;

   // The raw spans are exact powers of two times the screen spans.
   localparam int unsigned X_SHIFT = $clog2(RAW_X_SPAN / SCR_X_SPAN);
   localparam int unsigned Y_SHIFT = $clog2(RAW_Y_SPAN / SCR_Y_SPAN);

   localparam int unsigned X_W = 10;
   localparam int unsigned Y_W = 9;
   localparam int unsigned EDGE_W = 10;
   localparam int unsigned CODE_W = 6;
   localparam int unsigned GROUP_W = 2;

   localparam logic [X_W-1:0] X_MAX = X_W'(SCR_X_SPAN - 1);
   localparam logic [Y_W-1:0] Y_MAX = Y_W'(SCR_Y_SPAN - 1);

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_POLL = 1'b1;

   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_STATUS = 2'd1;
   localparam logic [1:0] FAULT_POINT  = 2'd2;
   localparam logic [1:0] FAULT_UNDEF  = 2'd3;

   localparam int unsigned STATUS_READY_BIT = 7;
   localparam logic [3:0] COUNT_MASK = 4'h F;

   typedef struct packed {
      logic [GROUP_W-1:0] screen;
      logic [EDGE_W-1:0]  left;
      logic [EDGE_W-1:0]  top;
      logic [EDGE_W-1:0]  width;
      logic [EDGE_W-1:0]  height;
      logic [CODE_W-1:0]  code;
   } slot_type;

   typedef struct packed {
      logic               valid;
      logic [GROUP_W-1:0] screen;
      logic [X_W-1:0]     x;
      logic [Y_W-1:0]     y;
      logic [CODE_W-1:0]  code;
   } search_type;

endpackage

FILE: hdl/trhd_cell.sv
`timescale 1ns / 1ps

module trhd_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  trhd_pkg::slot_type   wr_slot,
   input  trhd_pkg::search_type search_in,
   output trhd_pkg::search_type search_out
);
   import trhd_pkg::*;

   slot_type   slot_ff;
   search_type search_ff;
   search_type search_in_next;
   logic [EDGE_W:0] right_edge;
   logic [EDGE_W:0] bottom_edge;
   logic            hit;

   assign right_edge  = {1'b0, slot_ff.left} + {1'b0, slot_ff.width};
   assign bottom_edge = {1'b0, slot_ff.top} + {1'b0, slot_ff.height};

   always_comb begin
      hit = (slot_ff.code != '0) && (slot_ff.screen == search_in.screen) &&
            (search_in.x >= slot_ff.left) &&
            ({1'b0, search_in.x} < right_edge) &&
            ({1'b0, search_in.y} >= slot_ff.top) &&
            ({2'b00, search_in.y} < bottom_edge);
      search_in_next = search_in;
      // An earlier slot that matched keeps its code.
      if ((search_in.code == '0) && hit) begin
         search_in_next.code = slot_ff.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.code <= '0;
      end else if (wr_en) begin
         slot_ff.code <= wr_slot.code;
      end
      if (wr_en) begin
         slot_ff.screen <= wr_slot.screen;
         slot_ff.left   <= wr_slot.left;
         slot_ff.top    <= wr_slot.top;
         slot_ff.width  <= wr_slot.width;
         slot_ff.height <= wr_slot.height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff.valid <= 1'b0;
      end else begin
         search_ff.valid <= search_in_next.valid;
      end
      search_ff.screen <= search_in_next.screen;
      search_ff.x      <= search_in_next.x;
      search_ff.y      <= search_in_next.y;
      search_ff.code   <= search_in_next.code;
   end

   assign search_out = search_ff;

endmodule

FILE: hdl/touch_region_hit_detector_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                     Transfer
// request   start, busy, req_*                        start high while busy low
// response  rsp_valid, rsp_*                          one cycle with rsp_valid high
//
// A load word, or a poll that needs no search, gives its response through the
// finish_ff and rsp_valid_ff registers. A poll that reports a new press sends
// its point from launch_ff through the row of REGION_SLOTS slot cells, one cell
// per cycle; its response is then registered in rsp_valid_ff.
// Busy is low again in the response cycle. Reset clears every slot code, the
// held-finger flag and all control state. The receiver cannot stall responses.

module touch_region_hit_detector_core #(
   parameter int unsigned REGION_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [1:0]  req_screen,
   input  logic [5:0]  req_region_index,
   input  logic [9:0]  req_region_left,
   input  logic [9:0]  req_region_top,
   input  logic [9:0]  req_region_width,
   input  logic [9:0]  req_region_height,
   input  logic [5:0]  req_region_code,
   input  logic [7:0]  req_status_byte,
   input  logic [1:0]  req_bus_fault,
   input  logic [15:0] req_raw_x,
   input  logic [15:0] req_raw_y,
   output logic        rsp_valid,
   output logic [5:0]  rsp_button_code,
   output logic [9:0]  rsp_screen_x,
   output logic [8:0]  rsp_screen_y,
   output logic        rsp_clear_request,
   output logic        rsp_new_press
);
   import trhd_pkg::*;

   logic busy_ff, finish_ff, launch_ff, finger_held_ff;
   logic finish_in, launch_in, finger_held_in;
   logic [GROUP_W-1:0] grp_ff;
   logic [X_W-1:0] pend_x_ff, pend_x_in;
   logic [Y_W-1:0] pend_y_ff, pend_y_in;
   logic pend_clr_ff, pend_clr_in, pend_np_ff, pend_np_in;
   logic rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic [X_W-1:0] rsp_x_ff;
   logic [Y_W-1:0] rsp_y_ff;
   logic rsp_clr_ff, rsp_np_ff;

   logic accept, load_accept;
   logic status_fault, touch_absent, in_range;
   logic [15-X_SHIFT:0] scaled_x;
   logic [15-Y_SHIFT:0] scaled_y;
   logic [X_W-1:0] point_x;
   logic [Y_W-1:0] point_y;
   slot_type wr_slot;
   search_type chain [0:REGION_SLOTS];

   assign accept      = start && !busy_ff;
   assign load_accept = accept && (req_action == ACTION_LOAD);

   assign status_fault = (req_bus_fault == FAULT_STATUS) || (req_bus_fault == FAULT_UNDEF);
   assign touch_absent = !req_status_byte[STATUS_READY_BIT] ||
                         ((req_status_byte[3:0] & COUNT_MASK) == '0);

   assign in_range = (req_raw_x < 16'(SCR_X_SPAN)) && (req_raw_y < 16'(SCR_Y_SPAN));
   assign scaled_x = req_raw_x[15:X_SHIFT];
   assign scaled_y = req_raw_y[15:Y_SHIFT];

   always_comb begin
      if (in_range) begin
         point_x = req_raw_x[X_W-1:0];
         point_y = req_raw_y[Y_W-1:0];
      end else begin
         point_x = (scaled_x > (16-X_SHIFT)'(X_MAX)) ? X_MAX : scaled_x[X_W-1:0];
         point_y = (scaled_y > (16-Y_SHIFT)'(Y_MAX)) ? Y_MAX : scaled_y[Y_W-1:0];
      end
   end

   always_comb begin
      finish_in      = 1'b0;
      launch_in      = 1'b0;
      finger_held_in = finger_held_ff;
      pend_x_in      = '0;
      pend_y_in      = '0;
      pend_clr_in    = 1'b0;
      pend_np_in     = 1'b0;
      if (req_action == ACTION_LOAD) begin
         finish_in = 1'b1;
      end else if (status_fault) begin
         finish_in = 1'b1;
      end else if (touch_absent) begin
         finish_in      = 1'b1;
         pend_clr_in    = 1'b1;
         finger_held_in = 1'b0;
      end else if (finger_held_ff) begin
         finish_in   = 1'b1;
         pend_clr_in = 1'b1;
      end else begin
         finger_held_in = 1'b1;
         pend_clr_in    = 1'b1;
         if (req_bus_fault == FAULT_NONE) begin
            launch_in  = 1'b1;
            pend_np_in = 1'b1;
            pend_x_in  = point_x;
            pend_y_in  = point_y;
         end else begin
            finish_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         finish_ff      <= 1'b0;
         launch_ff      <= 1'b0;
         finger_held_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         finish_ff    <= accept && finish_in;
         launch_ff    <= accept && launch_in;
         rsp_valid_ff <= finish_ff || chain[REGION_SLOTS].valid;
         if (accept) begin
            busy_ff        <= 1'b1;
            finger_held_ff <= finger_held_in;
         end else if (finish_ff || chain[REGION_SLOTS].valid) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff      <= req_screen;
         pend_x_ff   <= pend_x_in;
         pend_y_ff   <= pend_y_in;
         pend_clr_ff <= pend_clr_in;
         pend_np_ff  <= pend_np_in;
      end
      if (finish_ff || chain[REGION_SLOTS].valid) begin
         rsp_code_ff <= chain[REGION_SLOTS].valid ? chain[REGION_SLOTS].code : '0;
         rsp_x_ff    <= pend_x_ff;
         rsp_y_ff    <= pend_y_ff;
         rsp_clr_ff  <= pend_clr_ff;
         rsp_np_ff   <= pend_np_ff;
      end
   end

   assign wr_slot.screen = req_screen;
   assign wr_slot.left   = req_region_left;
   assign wr_slot.top    = req_region_top;
   assign wr_slot.width  = req_region_width;
   assign wr_slot.height = req_region_height;
   assign wr_slot.code   = req_region_code;

   assign chain[0].valid  = launch_ff;
   assign chain[0].screen = grp_ff;
   assign chain[0].x      = pend_x_ff;
   assign chain[0].y      = pend_y_ff;
   assign chain[0].code   = '0;

   for (genvar i = 0; i < REGION_SLOTS; i++) begin : g_cell
      logic wr_en;
      assign wr_en = load_accept && ({26'd0, req_region_index} == 32'(i));
      trhd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en),
         .wr_slot    (wr_slot),
         .search_in  (chain[i]),
         .search_out (chain[i+1])
      );
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_button_code   = rsp_code_ff;
   assign rsp_screen_x      = rsp_x_ff;
   assign rsp_screen_y      = rsp_y_ff;
   assign rsp_clear_request = rsp_clr_ff;
   assign rsp_new_press     = rsp_np_ff;

   a_token_while_busy: assert property (@(posedge clock) disable iff (reset)
      chain[REGION_SLOTS].valid |-> busy_ff)
      else $error("search word leaves the cell row while the block is idle");

   a_single_source: assert property (@(posedge clock) disable iff (reset)
      $onehot0({finish_ff, launch_ff, chain[REGION_SLOTS].valid}))
      else $error("more than one completion source active");

   a_code_needs_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_code_ff != '0)) |-> (rsp_np_ff && rsp_clr_ff))
      else $error("button code reported without a new press");

   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("busy still set in the response cycle");

endmodule
